/* sv/sn2d_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package sn2d_pkg;

  // table geometry
  localparam int TBL_BITS = 11;
  localparam int TBL_SIZE = 1 << TBL_BITS;
  localparam int DIV_W    = TBL_BITS + 1;

  // fixed point formats
  localparam int FRAC_BITS = 16;
  localparam int WF        = 28;
  localparam int SKEW_SH   = FRAC_BITS + 30;
  localparam int XSI_LSB   = FRAC_BITS + 2;
  localparam int OUT_SH    = 44 - FRAC_BITS;
  localparam int GRAD_FRAC = 20;
  localparam int GRAD_W    = 22;
  localparam int NOISE_W   = 20;

  // shared multiplier and divider
  localparam int MUL_W  = 33;
  localparam int PROD_W = 2 * MUL_W;
  localparam int DVD_W  = 64;
  localparam int CNT_W  = $clog2(DVD_W);

  // lcg
  localparam logic [63:0] LCG_MUL   = 64'd6364136223846793005;
  localparam logic [63:0] LCG_ADD   = 64'd1442695040888963407;
  localparam logic [63:0] SEED_BIAS = 64'd31;

  // lattice constants
  localparam logic signed [MUL_W-1:0] SKEW_Q30    = 33'sd393016785;
  localparam logic signed [MUL_W-1:0] NEG_UNSKEW  = -33'sd56727087;
  localparam logic signed [MUL_W-1:0] INV_N2_Q16  = 33'sd1195505;
  localparam logic signed [36:0]      TWO_THIRDS  = 37'sd178956971;
  localparam logic signed [37:0]      OUT_MAX     = 38'sd524287;
  localparam logic signed [37:0]      OUT_MIN     = -38'sd524288;

  localparam logic signed [GRAD_W-1:0] C1 = 22'sd136867;
  localparam logic signed [GRAD_W-1:0] C2 = 22'sd401273;
  localparam logic signed [GRAD_W-1:0] C3 = 22'sd638333;
  localparam logic signed [GRAD_W-1:0] C4 = 22'sd831891;
  localparam logic signed [GRAD_W-1:0] C5 = 22'sd968758;
  localparam logic signed [GRAD_W-1:0] C6 = 22'sd1039605;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_R_INIT, ST_R_M0, ST_R_M1, ST_R_M2, ST_R_M3, ST_R_DIVS, ST_R_DIVW, ST_R_RD, ST_R_WR,
    ST_SKEW, ST_SKEW_W, ST_LATT, ST_UNSK, ST_DXY, ST_SQX, ST_SQY, ST_ATTN, ST_ATTN2,
    ST_A2, ST_A4, ST_GX, ST_GY, ST_EXT, ST_CTB, ST_ACC, ST_NEXT, ST_FIN, ST_OUT
  } seq_state_t;

  // table port requests and read data
  typedef struct packed {
    logic                ss_we;
    logic [TBL_BITS-1:0] ss_waddr;
    logic [TBL_BITS-1:0] ss_wdata;
    logic                ss_re;
    logic [TBL_BITS-1:0] ss_raddr_a;
    logic [TBL_BITS-1:0] ss_raddr_b;
    logic                pg_we;
    logic [TBL_BITS-1:0] pg_waddr;
    logic [TBL_BITS-1:0] pg_wdata;
    logic                perm_re;
    logic [TBL_BITS-1:0] perm_raddr;
    logic                grad_re;
    logic [TBL_BITS-1:0] grad_raddr;
  } tbl_req_t;

  typedef struct packed {
    logic [TBL_BITS-1:0] ss_a_q;
    logic [TBL_BITS-1:0] ss_b_q;
    logic [TBL_BITS-1:0] perm_q;
    logic [4:0]          grad_q;
  } tbl_rsp_t;

  typedef struct packed {
    logic [2:0] xv;
    logic [2:0] yv;
  } corner_t;

  // unit gradient x component, q20
  function automatic logic signed [GRAD_W-1:0] grad_x(input logic [4:0] gi);
    logic signed [GRAD_W-1:0] v;
    case (gi)
      5'd0:  v = C1;   5'd1:  v = C2;   5'd2:  v = C3;   5'd3:  v = C4;
      5'd4:  v = C5;   5'd5:  v = C6;   5'd6:  v = C6;   5'd7:  v = C5;
      5'd8:  v = C4;   5'd9:  v = C3;   5'd10: v = C2;   5'd11: v = C1;
      5'd12: v = -C1;  5'd13: v = -C2;  5'd14: v = -C3;  5'd15: v = -C4;
      5'd16: v = -C5;  5'd17: v = -C6;  5'd18: v = -C6;  5'd19: v = -C5;
      5'd20: v = -C4;  5'd21: v = -C3;  5'd22: v = -C2;  5'd23: v = -C1;
      default: v = '0;
    endcase
    return v;
  endfunction

  // unit gradient y component, q20
  function automatic logic signed [GRAD_W-1:0] grad_y(input logic [4:0] gi);
    logic signed [GRAD_W-1:0] v;
    case (gi)
      5'd0:  v = C6;   5'd1:  v = C5;   5'd2:  v = C4;   5'd3:  v = C3;
      5'd4:  v = C2;   5'd5:  v = C1;   5'd6:  v = -C1;  5'd7:  v = -C2;
      5'd8:  v = -C3;  5'd9:  v = -C4;  5'd10: v = -C5;  5'd11: v = -C6;
      5'd12: v = -C6;  5'd13: v = -C5;  5'd14: v = -C4;  5'd15: v = -C3;
      5'd16: v = -C2;  5'd17: v = -C1;  5'd18: v = C1;   5'd19: v = C2;
      5'd20: v = C3;   5'd21: v = C4;   5'd22: v = C5;   5'd23: v = C6;
      default: v = '0;
    endcase
    return v;
  endfunction

  // lattice offset of corner k within lookup group g
  function automatic corner_t corner_off(input logic [2:0] g, input logic [1:0] k);
    corner_t c;
    logic [11:0] row;
    case (g)
      3'd0: row = {3'b111, 3'b000, 3'b000, 3'b111};
      3'd1: row = {3'b000, 3'b001, 3'b001, 3'b000};
      3'd2: row = {3'b001, 3'b000, 3'b000, 3'b111};
      3'd3: row = {3'b010, 3'b001, 3'b001, 3'b000};
      3'd4: row = {3'b111, 3'b000, 3'b000, 3'b001};
      3'd5: row = {3'b000, 3'b001, 3'b001, 3'b010};
      3'd6: row = {3'b001, 3'b000, 3'b000, 3'b001};
      3'd7: row = {3'b010, 3'b001, 3'b001, 3'b010};
      default: row = '0;
    endcase
    case (k)
      2'd0: c = '{xv: 3'd0, yv: 3'd0};
      2'd1: c = '{xv: 3'd1, yv: 3'd1};
      2'd2: c = '{xv: row[11:9], yv: row[8:6]};
      2'd3: c = '{xv: row[5:3], yv: row[2:0]};
      default: c = '0;
    endcase
    return c;
  endfunction

  // t * unskew magnitude, q28, for t in -1..4
  function automatic logic signed [31:0] unsk_off(input logic [3:0] t);
    logic signed [31:0] v;
    case (t)
      4'hF: v = -32'sd56727087;
      4'h0: v = 32'sd0;
      4'h1: v = 32'sd56727087;
      4'h2: v = 32'sd113454174;
      4'h3: v = 32'sd170181261;
      4'h4: v = 32'sd226908348;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* sv/sn2d_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
module sn2d_mul import sn2d_pkg::*; (
  input  wire logic                     clk,
  input  wire logic signed [MUL_W-1:0]  op_a,
  input  wire logic signed [MUL_W-1:0]  op_b,
  output logic signed [PROD_W-1:0]      product
);

  logic signed [PROD_W-1:0] product_r;

  // registered signed product
  always_ff @(posedge clk) begin
    product_r <= op_a * op_b;
  end

  assign product = product_r;

endmodule
`default_nettype wire

/* sv/sn2d_div.sv */
`timescale 1ns / 1ps
`default_nettype none
module sn2d_div import sn2d_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [DVD_W-1:0]    dividend,
  input  wire logic [DIV_W-1:0]    divisor,
  output logic                     done,
  output logic [TBL_BITS-1:0]      remainder
);

  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DVD_W-1:0]    num_r, num_nxt;
  logic [TBL_BITS-1:0] rem_r, rem_nxt;
  logic [DIV_W-1:0]    trial;
  logic [DIV_W-1:0]    diff;

  // one quotient bit per cycle, restoring
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, num_r[DVD_W-1]};
    diff     = trial - divisor;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      num_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      num_nxt = {num_r[DVD_W-2:0], 1'b0};
      if (trial >= divisor) begin
        rem_nxt = diff[TBL_BITS-1:0];
      end else begin
        rem_nxt = trial[TBL_BITS-1:0];
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

/* sv/sn2d_tbl.sv */
`timescale 1ns / 1ps
`default_nettype none
module sn2d_tbl import sn2d_pkg::*; (
  input  wire logic     clk,
  input  wire tbl_req_t req,
  output tbl_rsp_t      rsp
);

  logic [TBL_BITS-1:0] perm_mem [TBL_SIZE];
  logic [4:0]          grad_mem [TBL_SIZE];
  logic [TBL_BITS-1:0] ss_mem   [TBL_SIZE];

  logic [TBL_BITS-1:0] perm_q_r;
  logic [4:0]          grad_q_r;
  logic [TBL_BITS-1:0] ss_a_q_r;
  logic [TBL_BITS-1:0] ss_b_q_r;
  logic [4:0]          grad_wdata;

  // remainder by 3 of an 8-bit value, bit by bit
  function automatic logic [1:0] mod3(input logic [7:0] v);
    logic [2:0] acc;
    acc = '0;
    for (int i = 7; i >= 0; i--) begin
      acc = {acc[1:0], v[i]};
      if (acc >= 3'd3) begin
        acc = acc - 3'd3;
      end
    end
    return acc[1:0];
  endfunction

  // entry mod 24 = 8 * ((entry / 8) mod 3) + entry mod 8
  assign grad_wdata = {mod3(8'(req.pg_wdata[TBL_BITS-1:3])), req.pg_wdata[2:0]};

  // permutation and gradient index tables
  always_ff @(posedge clk) begin
    if (req.pg_we) begin
      perm_mem[req.pg_waddr] <= req.pg_wdata;
      grad_mem[req.pg_waddr] <= grad_wdata;
    end
    if (req.perm_re) begin
      perm_q_r <= perm_mem[req.perm_raddr];
    end
    if (req.grad_re) begin
      grad_q_r <= grad_mem[req.grad_raddr];
    end
  end

  // shuffle source, two read ports
  always_ff @(posedge clk) begin
    if (req.ss_we) begin
      ss_mem[req.ss_waddr] <= req.ss_wdata;
    end
    if (req.ss_re) begin
      ss_a_q_r <= ss_mem[req.ss_raddr_a];
      ss_b_q_r <= ss_mem[req.ss_raddr_b];
    end
  end

  assign rsp.perm_q = perm_q_r;
  assign rsp.grad_q = grad_q_r;
  assign rsp.ss_a_q = ss_a_q_r;
  assign rsp.ss_b_q = ss_b_q_r;

endmodule
`default_nettype wire

/* sv/simplex_noise_2d.sv */
`timescale 1ns / 1ps
`default_nettype none
// 2-D OpenSimplex2 noise. Raise start for one cycle while busy is low; busy then
// stays high until the result appears. Each request gives exactly one result,
// shown for a single cycle with out_valid, which the receiver must take then:
// there is no way to hold it off. A reseed request (in_operation = 1) shuffles the
// 2048-entry permutation from the seed register and answers with out_reseed_ack = 1
// and zero noise; it fills the shuffle source, then draws each entry with one LCG
// step and the one-bit-a-cycle 64-bit modulo unit. A sample request sends all its
// products through one shared 33x33 multiplier and runs 4 setup steps, 13 steps
// per lattice corner that contributes and 6 per corner that does not, and 2 to
// scale and saturate. Reseed at least once before sampling. Write the seed only
// while busy is low.
module simplex_noise_2d import sn2d_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic                       in_operation,
  input  wire logic signed [31:0]         in_x_coord,
  input  wire logic signed [31:0]         in_y_coord,
  output logic                            out_valid,
  output logic signed [NOISE_W-1:0]       out_noise_value,
  output logic                            out_reseed_ack,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic signed [63:0]         cfg_seed
);

  seq_state_t state_r, state_nxt;

  logic [63:0]                seed_r;
  logic [63:0]                st_r, st_nxt;
  logic [63:0]                lo_r, lo_nxt;
  logic [31:0]                cross_r, cross_nxt;
  logic [TBL_BITS-1:0]        idx_r, idx_nxt;
  logic [TBL_BITS-1:0]        r_r, r_nxt;
  logic                       neg_r, neg_nxt;

  logic signed [31:0]         x_r, x_nxt;
  logic signed [31:0]         y_r, y_nxt;
  logic [TBL_BITS-1:0]        xsb_r, xsb_nxt;
  logic [TBL_BITS-1:0]        ysb_r, ysb_nxt;
  logic [WF-1:0]              xsi_r, xsi_nxt;
  logic [WF-1:0]              ysi_r, ysi_nxt;
  logic [2:0]                 g_r, g_nxt;
  logic signed [WF+1:0]       xi_r, xi_nxt;
  logic signed [WF+1:0]       yi_r, yi_nxt;
  logic [1:0]                 k_r, k_nxt;
  logic signed [31:0]         dx_r, dx_nxt;
  logic signed [31:0]         dy_r, dy_nxt;
  logic [TBL_BITS-1:0]        pxm_r, pxm_nxt;
  logic [TBL_BITS-1:0]        pym_r, pym_nxt;
  logic [63:0]                sq_r, sq_nxt;
  logic [WF-1:0]              attn_r, attn_nxt;
  logic signed [GRAD_W-1:0]   gx_r, gx_nxt;
  logic signed [GRAD_W-1:0]   gy_r, gy_nxt;
  logic [WF-1:0]              a4_r, a4_nxt;
  logic signed [55:0]         dot_r, dot_nxt;
  logic signed [31:0]         ext_r, ext_nxt;
  logic signed [63:0]         acc_r, acc_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic                       out_ack_r, out_ack_nxt;
  logic signed [NOISE_W-1:0]  out_noise_r, out_noise_nxt;

  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic                       div_start;
  logic [DVD_W-1:0]           div_dividend;
  logic [DIV_W-1:0]           div_n;
  logic                       div_done;
  logic [TBL_BITS-1:0]        div_rem;
  tbl_req_t                   tbl_req;
  tbl_rsp_t                   tbl_rsp;

  sn2d_mul u_mul (
    .clk     (clk),
    .op_a    (mul_a),
    .op_b    (mul_b),
    .product (mul_p)
  );

  sn2d_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_n),
    .done      (div_done),
    .remainder (div_rem)
  );

  sn2d_tbl u_tbl (
    .clk (clk),
    .req (tbl_req),
    .rsp (tbl_rsp)
  );

  // draw range for entry i is i + 1
  assign div_n = {1'b0, idx_r} + DIV_W'(1);

  // sequencer and datapath
  always_comb begin
    logic signed [65:0]    xs, ys;
    logic [WF:0]           sum_si;
    logic signed [WF+2:0]  t3, t4, a_lim;
    logic signed [WF+1:0]  ssi;
    corner_t               co;
    logic [3:0]            tsum;
    logic [63:0]           vpos, vneg;
    logic signed [36:0]    attn_full;
    logic signed [55:0]    dot;
    logic signed [37:0]    res;
    logic [DIV_W-1:0]      rdiff;

    state_nxt     = state_r;
    st_nxt        = st_r;
    lo_nxt        = lo_r;
    cross_nxt     = cross_r;
    idx_nxt       = idx_r;
    r_nxt         = r_r;
    neg_nxt       = neg_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    xsb_nxt       = xsb_r;
    ysb_nxt       = ysb_r;
    xsi_nxt       = xsi_r;
    ysi_nxt       = ysi_r;
    g_nxt         = g_r;
    xi_nxt        = xi_r;
    yi_nxt        = yi_r;
    k_nxt         = k_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    pxm_nxt       = pxm_r;
    pym_nxt       = pym_r;
    sq_nxt        = sq_r;
    attn_nxt      = attn_r;
    gx_nxt        = gx_r;
    gy_nxt        = gy_r;
    a4_nxt        = a4_r;
    dot_nxt       = dot_r;
    ext_nxt       = ext_r;
    acc_nxt       = acc_r;
    out_valid_nxt = 1'b0;
    out_ack_nxt   = out_ack_r;
    out_noise_nxt = out_noise_r;
    mul_a         = '0;
    mul_b         = '0;
    div_start     = 1'b0;
    div_dividend  = '0;
    tbl_req       = '0;

    xs        = $signed({{4{x_r[31]}}, x_r, 30'b0}) + mul_p;
    ys        = $signed({{4{y_r[31]}}, y_r, 30'b0}) + mul_p;
    sum_si    = {1'b0, xsi_r} + {1'b0, ysi_r};
    t3        = $signed({2'b00, xsi_r, 1'b0}) - $signed({3'b000, ysi_r});
    t4        = $signed({2'b00, ysi_r, 1'b0}) - $signed({3'b000, xsi_r});
    a_lim     = $signed({2'b00, sum_si[WF], {WF{1'b0}}});
    ssi       = mul_p[WF +: WF+2];
    co        = corner_off(g_r, k_r);
    tsum      = {co.xv[2], co.xv} + {co.yv[2], co.yv};
    vpos      = st_r + SEED_BIAS;
    vneg      = ~st_r - (SEED_BIAS - 64'd1);
    attn_full = TWO_THIRDS - $signed({1'b0, sq_r[63:WF]});
    dot       = dot_r + mul_p[55:0];
    res       = mul_p[OUT_SH +: 38];
    rdiff     = div_n - {1'b0, div_rem};

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          x_nxt = in_x_coord;
          y_nxt = in_y_coord;
          if (in_operation) begin
            idx_nxt   = '0;
            state_nxt = ST_R_INIT;
          end else begin
            state_nxt = ST_SKEW;
          end
        end
      end

      // shuffle source starts as the identity
      ST_R_INIT: begin
        tbl_req.ss_we    = 1'b1;
        tbl_req.ss_waddr = idx_r;
        tbl_req.ss_wdata = idx_r;
        if (idx_r == '1) begin
          st_nxt    = seed_r;
          state_nxt = ST_R_M0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      // lcg step, low 64 bits of st * mul + add from three 32x32 products
      ST_R_M0: begin
        mul_a     = {1'b0, st_r[31:0]};
        mul_b     = {1'b0, LCG_MUL[31:0]};
        state_nxt = ST_R_M1;
      end
      ST_R_M1: begin
        lo_nxt    = mul_p[63:0] + LCG_ADD;
        mul_a     = {1'b0, st_r[63:32]};
        mul_b     = {1'b0, LCG_MUL[31:0]};
        state_nxt = ST_R_M2;
      end
      ST_R_M2: begin
        cross_nxt = mul_p[31:0];
        mul_a     = {1'b0, st_r[31:0]};
        mul_b     = {1'b0, LCG_MUL[63:32]};
        state_nxt = ST_R_M3;
      end
      ST_R_M3: begin
        st_nxt    = {lo_r[63:32] + cross_r + mul_p[31:0], lo_r[31:0]};
        state_nxt = ST_R_DIVS;
      end

      // biased value, magnitude into the modulo unit
      ST_R_DIVS: begin
        neg_nxt      = vpos[63];
        div_dividend = vpos[63] ? vneg : vpos;
        div_start    = 1'b1;
        state_nxt    = ST_R_DIVW;
      end
      ST_R_DIVW: begin
        if (div_done) begin
          if (neg_r && (div_rem != '0)) begin
            r_nxt = rdiff[TBL_BITS-1:0];
          end else if (neg_r) begin
            r_nxt = '0;
          end else begin
            r_nxt = div_rem;
          end
          state_nxt = ST_R_RD;
        end
      end
      ST_R_RD: begin
        tbl_req.ss_re      = 1'b1;
        tbl_req.ss_raddr_a = r_r;
        tbl_req.ss_raddr_b = idx_r;
        state_nxt          = ST_R_WR;
      end

      // swap step of the shuffle
      ST_R_WR: begin
        tbl_req.pg_we    = 1'b1;
        tbl_req.pg_waddr = idx_r;
        tbl_req.pg_wdata = tbl_rsp.ss_a_q;
        tbl_req.ss_we    = 1'b1;
        tbl_req.ss_waddr = r_r;
        tbl_req.ss_wdata = tbl_rsp.ss_b_q;
        if (idx_r == '0) begin
          out_valid_nxt = 1'b1;
          out_ack_nxt   = 1'b1;
          out_noise_nxt = '0;
          state_nxt     = ST_IDLE;
        end else begin
          idx_nxt   = idx_r - 1'b1;
          state_nxt = ST_R_M0;
        end
      end

      // skew onto the simplex lattice
      ST_SKEW: begin
        mul_a     = {x_r[31], x_r} + {y_r[31], y_r};
        mul_b     = SKEW_Q30;
        state_nxt = ST_SKEW_W;
      end
      ST_SKEW_W: begin
        xsb_nxt   = xs[SKEW_SH +: TBL_BITS];
        ysb_nxt   = ys[SKEW_SH +: TBL_BITS];
        xsi_nxt   = xs[XSI_LSB +: WF];
        ysi_nxt   = ys[XSI_LSB +: WF];
        state_nxt = ST_LATT;
      end

      // lookup group and unskew of the cell fraction
      ST_LATT: begin
        g_nxt     = {t4 >= a_lim, t3 >= a_lim, sum_si[WF]};
        mul_a     = {4'b0, sum_si};
        mul_b     = NEG_UNSKEW;
        state_nxt = ST_UNSK;
      end
      ST_UNSK: begin
        xi_nxt    = $signed({2'b00, xsi_r}) + ssi;
        yi_nxt    = $signed({2'b00, ysi_r}) + ssi;
        k_nxt     = '0;
        acc_nxt   = '0;
        state_nxt = ST_DXY;
      end

      // per corner: offsets and hash coordinates
      ST_DXY: begin
        dx_nxt = {{2{xi_r[WF+1]}}, xi_r} - $signed({co.xv[2], co.xv, {WF{1'b0}}})
                 + unsk_off(tsum);
        dy_nxt = {{2{yi_r[WF+1]}}, yi_r} - $signed({co.yv[2], co.yv, {WF{1'b0}}})
                 + unsk_off(tsum);
        pxm_nxt   = xsb_r + {{(TBL_BITS-3){co.xv[2]}}, co.xv};
        pym_nxt   = ysb_r + {{(TBL_BITS-3){co.yv[2]}}, co.yv};
        state_nxt = ST_SQX;
      end
      ST_SQX: begin
        mul_a     = {dx_r[31], dx_r};
        mul_b     = {dx_r[31], dx_r};
        state_nxt = ST_SQY;
      end
      ST_SQY: begin
        sq_nxt             = mul_p[63:0];
        mul_a              = {dy_r[31], dy_r};
        mul_b              = {dy_r[31], dy_r};
        tbl_req.perm_re    = 1'b1;
        tbl_req.perm_raddr = pxm_r;
        state_nxt          = ST_ATTN;
      end
      ST_ATTN: begin
        sq_nxt    = sq_r + mul_p[63:0];
        state_nxt = ST_ATTN2;
      end

      // corners outside the kernel radius add nothing
      ST_ATTN2: begin
        if (!attn_full[36] && (attn_full != '0)) begin
          attn_nxt           = attn_full[WF-1:0];
          tbl_req.grad_re    = 1'b1;
          tbl_req.grad_raddr = tbl_rsp.perm_q ^ pym_r;
          state_nxt          = ST_A2;
        end else begin
          state_nxt = ST_NEXT;
        end
      end
      ST_A2: begin
        mul_a     = {5'b0, attn_r};
        mul_b     = {5'b0, attn_r};
        gx_nxt    = grad_x(tbl_rsp.grad_q);
        gy_nxt    = grad_y(tbl_rsp.grad_q);
        state_nxt = ST_A4;
      end
      ST_A4: begin
        mul_a     = {5'b0, mul_p[WF +: WF]};
        mul_b     = {5'b0, mul_p[WF +: WF]};
        state_nxt = ST_GX;
      end
      ST_GX: begin
        a4_nxt    = mul_p[WF +: WF];
        mul_a     = {{(MUL_W-GRAD_W){gx_r[GRAD_W-1]}}, gx_r};
        mul_b     = {dx_r[31], dx_r};
        state_nxt = ST_GY;
      end
      ST_GY: begin
        dot_nxt   = mul_p[55:0];
        mul_a     = {{(MUL_W-GRAD_W){gy_r[GRAD_W-1]}}, gy_r};
        mul_b     = {dy_r[31], dy_r};
        state_nxt = ST_EXT;
      end
      ST_EXT: begin
        ext_nxt   = dot[GRAD_FRAC +: 32];
        state_nxt = ST_CTB;
      end
      ST_CTB: begin
        mul_a     = {5'b0, a4_r};
        mul_b     = {ext_r[31], ext_r};
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        acc_nxt   = acc_r + mul_p[63:0];
        state_nxt = ST_NEXT;
      end
      ST_NEXT: begin
        if (k_r == 2'd3) begin
          state_nxt = ST_FIN;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_DXY;
        end
      end

      // scale by 1/n2 and saturate
      ST_FIN: begin
        mul_a     = acc_r[WF +: MUL_W];
        mul_b     = INV_N2_Q16;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (res > OUT_MAX) begin
          out_noise_nxt = OUT_MAX[NOISE_W-1:0];
        end else if (res < OUT_MIN) begin
          out_noise_nxt = OUT_MIN[NOISE_W-1:0];
        end else begin
          out_noise_nxt = res[NOISE_W-1:0];
        end
        out_valid_nxt = 1'b1;
        out_ack_nxt   = 1'b0;
        state_nxt     = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state and seed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      seed_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        seed_r <= cfg_seed;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    st_r        <= st_nxt;
    lo_r        <= lo_nxt;
    cross_r     <= cross_nxt;
    idx_r       <= idx_nxt;
    r_r         <= r_nxt;
    neg_r       <= neg_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    xsb_r       <= xsb_nxt;
    ysb_r       <= ysb_nxt;
    xsi_r       <= xsi_nxt;
    ysi_r       <= ysi_nxt;
    g_r         <= g_nxt;
    xi_r        <= xi_nxt;
    yi_r        <= yi_nxt;
    k_r         <= k_nxt;
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    pxm_r       <= pxm_nxt;
    pym_r       <= pym_nxt;
    sq_r        <= sq_nxt;
    attn_r      <= attn_nxt;
    gx_r        <= gx_nxt;
    gy_r        <= gy_nxt;
    a4_r        <= a4_nxt;
    dot_r       <= dot_nxt;
    ext_r       <= ext_nxt;
    acc_r       <= acc_nxt;
    out_ack_r   <= out_ack_nxt;
    out_noise_r <= out_noise_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign cfg_ready       = (state_r == ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_reseed_ack  = out_ack_r;
  assign out_noise_value = out_noise_r;

  // result strobe lasts one cycle
  ap_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // every request ends with its result
  ap_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("busy dropped without a result");

  // a reseed answer carries no noise
  ap_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_reseed_ack) |-> (out_noise_value == '0))
    else $error("reseed result with nonzero noise");

  // an accepted request makes the block busy
  ap_take: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

endmodule
`default_nettype wire
